[sv/i2c_register_file_slave_top_assert.svh]
// Assertion macros for the I2C register file slave.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef I2C_REGISTER_FILE_SLAVE_TOP_ASSERT_SVH
`define I2C_REGISTER_FILE_SLAVE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c register file slave: check failed");

// next-cycle implication, checked out of reset
`define RF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c register file slave: check failed");

`endif

[sv/i2crf_pkg.sv]
// Shared types and constants for the I2C register file slave.
// No dependencies; used by i2crf_ctrl, i2crf_dpath and the top level.
package i2crf_pkg;

	localparam int unsigned RF_REG_COUNT = 256;
	localparam int unsigned ADDR_W       = 7;
	localparam int unsigned BYTE_W       = 8;

	// register map defaults
	localparam logic [7:0] MODE1_IDX      = 8'h00;
	localparam logic [7:0] MODE2_IDX      = 8'h01;
	localparam logic [7:0] PRESCALE_IDX   = 8'hFE;
	localparam logic [7:0] MODE1_RST      = 8'h11;
	localparam logic [7:0] MODE2_RST      = 8'h04;
	localparam logic [7:0] PRESCALE_RST   = 8'h1E;
	localparam int unsigned AUTO_INC_BIT  = 5;
	localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'd64;

	// reply kinds
	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_READ = 1'b1;
	localparam logic [7:0] ACK_DATA = 8'h01;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request, apply stop and start
		logic emit;     // load the output register
		logic kind;     // reply kind for emit
		logic last;     // last reply of this request
		logic wr_op;    // pointer load or register store
		logic rd_bump;  // pointer advance after a read
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;       // start matched the device address
		logic do_wr;     // selected and write byte present
		logic do_rd;     // selected and read requested
		logic out_free;  // output register can take a reply
	} sts_t;

	// value of a register entry that was never written since reset
	function automatic logic [7:0] reset_value(input logic [7:0] idx);
		logic [7:0] v;
		v = 8'h00;
		if (idx == MODE1_IDX)    v = MODE1_RST;
		if (idx == MODE2_IDX)    v = MODE2_RST;
		if (idx == PRESCALE_IDX) v = PRESCALE_RST;
		return v;
	endfunction

endpackage

[sv/i2crf_ctrl.sv]
// Request sequencer for the I2C register file slave.
// Depends on i2crf_pkg; drives i2crf_dpath through cmd_t and reads sts_t.
module i2crf_ctrl
	import i2crf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WRITE,
		ST_READ,
		ST_RDATA
	} state_t;

	state_t state_q, state_n;
	logic   rdy_q;

	assign req_ready = rdy_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && rdy_q) begin
					cmd.load = 1'b1;
					state_n  = ST_START;
				end
			end
			ST_START: begin
				if (!sts.hit) begin
					state_n = ST_WRITE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_ACK;
					cmd.last = !(sts.do_wr || sts.do_rd);
					state_n  = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!sts.do_wr) begin
					state_n = sts.do_rd ? ST_READ : ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.kind  = KIND_ACK;
					cmd.last  = !sts.do_rd;
					cmd.wr_op = 1'b1;
					state_n   = sts.do_rd ? ST_READ : ST_IDLE;
				end
			end
			// memory read data is registered
			ST_READ: begin
				state_n = ST_RDATA;
			end
			ST_RDATA: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = KIND_READ;
					cmd.last    = 1'b1;
					cmd.rd_bump = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			state_q <= state_n;
			rdy_q   <= (state_n == ST_IDLE);
		end
	end

endmodule

[sv/i2crf_dpath.sv]
// Datapath for the I2C register file slave: register file, pointer, selection, output register.
// Depends on i2crf_pkg; commanded by i2crf_ctrl.
module i2crf_dpath
	import i2crf_pkg::*;
#(
	parameter int unsigned REGISTER_COUNT = RF_REG_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              stop_flag,
	input  logic              start_flag,
	input  logic              write_flag,
	input  logic              read_flag,
	input  logic [7:0]        address_byte,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_kind,
	output logic [7:0]        out_address,
	output logic [7:0]        out_data,
	output logic              out_last
);

	localparam int unsigned PTR_W = $clog2(REGISTER_COUNT);

	// register file; unwritten entries read as their reset value
	logic [7:0]       regs_q [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] written_q;
	logic [7:0]       rdata_q;
	logic             rvalid_q;

	logic [ADDR_W-1:0] dev_addr_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              sel_q;
	logic [7:0]        sel_addr_q;
	logic              ploaded_q;
	logic              auto_inc_q;
	logic              hit_q;
	logic              wr_q;
	logic              rd_q;
	logic [7:0]        wdata_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic              out_last_q;
	logic [7:0]        out_addr_q;
	logic [7:0]        out_data_q;

	logic              match;
	logic              wr_inc;
	logic [7:0]        rd_value;

	assign match    = (address_byte[7:1] == dev_addr_q);
	// a store to MODE1 sets the increment for its own pointer advance
	assign wr_inc   = (ptr_q == '0) ? wdata_q[AUTO_INC_BIT] : auto_inc_q;
	assign rd_value = rvalid_q ? rdata_q : reset_value(8'(ptr_q));

	assign sts.hit      = hit_q;
	assign sts.do_wr    = sel_q && wr_q;
	assign sts.do_rd    = sel_q && rd_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_last    = out_last_q;
	assign out_address = out_addr_q;
	assign out_data    = out_data_q;

	// device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_data;
		end
	end

	// selection, pointer and message flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q      <= 1'b0;
			sel_addr_q <= '0;
			ploaded_q  <= 1'b0;
			ptr_q      <= '0;
			auto_inc_q <= MODE1_RST[AUTO_INC_BIT];
			hit_q      <= 1'b0;
			wr_q       <= 1'b0;
			rd_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				wr_q  <= write_flag;
				rd_q  <= read_flag;
				hit_q <= start_flag && match;
				if (start_flag) begin
					sel_q      <= match;
					sel_addr_q <= match ? address_byte : 8'h00;
				end else if (stop_flag) begin
					sel_q      <= 1'b0;
					sel_addr_q <= 8'h00;
				end
				if (stop_flag) begin
					ploaded_q <= 1'b0;
				end
			end
			if (cmd.wr_op) begin
				if (!ploaded_q) begin
					ptr_q     <= PTR_W'(wdata_q);
					ploaded_q <= 1'b1;
				end else begin
					if (ptr_q == '0) begin
						auto_inc_q <= wdata_q[AUTO_INC_BIT];
					end
					if (wr_inc) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			end
			if (cmd.rd_bump && auto_inc_q) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// message data byte
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wdata_q <= data_byte;
		end
	end

	// written flags for the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (cmd.wr_op && ploaded_q) begin
			written_q[ptr_q] <= 1'b1;
		end
	end

	// register file write port and registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_op && ploaded_q) begin
			regs_q[ptr_q] <= wdata_q;
		end
		rdata_q  <= regs_q[ptr_q];
		rvalid_q <= written_q[ptr_q];
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			out_last_q <= cmd.last;
			out_addr_q <= sel_addr_q;
			out_data_q <= (cmd.kind == KIND_READ) ? rd_value : ACK_DATA;
		end
	end

endmodule

[sv/i2c_register_file_slave_top.sv]
// I2C register file slave, top level: stream ports, sequencer and datapath.
// Depends on i2crf_pkg, i2crf_ctrl, i2crf_dpath and i2c_register_file_slave_top_assert.svh.
//
// Takes one I2C bus message per request (stop, start, write, read, handled in that order)
// and returns up to three replies: start acknowledge, write acknowledge, read data, the
// final one marked with tlast. A 256-byte register file is written with auto-increment
// under MODE1 bit 5; after reset MODE1, MODE2 and the prescaler read their defaults. One
// message is handled at a time, and the output can stall it. The sequencer issues one reply
// per cycle while the output is not stalled, and a read waits on the registered register
// file port. No clearing pass is needed after reset.
module i2c_register_file_slave_top
	import i2crf_pkg::*;
#(
	parameter int unsigned REGISTER_COUNT = RF_REG_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data,   // device_address
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,    // address_byte, data_byte
	input  logic [3:0]        s_tuser,    // stop_flag, start_flag, write_flag, read_flag
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,    // reply_address, reply_data
	output logic [0:0]        m_tuser,    // reply_kind
	output logic              m_tlast     // last_reply
);

	cmd_t cmd;
	sts_t sts;

	i2crf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	i2crf_dpath #(
		.REGISTER_COUNT (REGISTER_COUNT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.stop_flag    (s_tuser[0]),
		.start_flag   (s_tuser[1]),
		.write_flag   (s_tuser[2]),
		.read_flag    (s_tuser[3]),
		.address_byte (s_tdata[7:0]),
		.data_byte    (s_tdata[15:8]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (m_tuser[0]),
		.out_address  (m_tdata[7:0]),
		.out_data     (m_tdata[15:8]),
		.out_last     (m_tlast)
	);

	// checks
	`include "i2c_register_file_slave_top_assert.svh"

	`RF_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
	`RF_ASSERT_SAME(a_read_is_last, m_tvalid && m_tuser[0], m_tlast)
	`RF_ASSERT_SAME(a_ack_data, m_tvalid && !m_tuser[0], m_tdata[15:8] == ACK_DATA)

endmodule

[sim/i2crf_reply_checker.sv]
// Reply checker for the I2C register file slave: watches both stream channels,
// predicts every reply from its own copy of the register file and compares.
// Depends on i2crf_pkg for widths, register map defaults and reply kinds.
module i2crf_reply_checker
	import i2crf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,    // address_byte, data_byte
	input  logic [3:0]        s_tuser,    // stop_flag, start_flag, write_flag, read_flag
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [15:0]       m_tdata,    // reply_address, reply_data
	input  logic [0:0]        m_tuser,    // reply_kind
	input  logic              m_tlast,    // last_reply
	output int                mismatch_count,
	output int                pending_replies,
	output int                message_count,
	output int                reply_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// request flag positions in s_tuser
	localparam int FLAG_STOP  = 0;
	localparam int FLAG_START = 1;
	localparam int FLAG_WRITE = 2;
	localparam int FLAG_READ  = 3;

	typedef struct {
		logic       kind;
		logic [7:0] addr;
		logic [7:0] data;
		logic       last;
	} reply_t;

	reply_t expected_replies[$];

	// shadow of the slave state
	logic [ADDR_W-1:0] dev_addr;
	logic [7:0]        reg_image [RF_REG_COUNT];
	logic [7:0]        reg_ptr;
	logic [7:0]        sel_addr;
	logic              sel_valid;
	logic              ptr_loaded;

	// auto-increment follows the current MODE1 bit
	task automatic step_pointer();
		if (reg_image[MODE1_IDX][AUTO_INC_BIT])
			reg_ptr = reg_ptr + 8'd1;
	endtask

	// stop, start, write, read in that order; queue the replies they cause
	task automatic predict_replies(input logic [3:0] flags, input logic [7:0] abyte,
			input logic [7:0] dbyte);
		reply_t batch[$];
		reply_t r;
		r.last = 1'b0;
		if (flags[FLAG_STOP]) begin
			sel_valid = 1'b0;
			sel_addr = 8'h00;
			ptr_loaded = 1'b0;
		end
		if (flags[FLAG_START]) begin
			sel_valid = 1'b0;
			sel_addr = 8'h00;
			if (abyte[7:1] == dev_addr) begin
				sel_valid = 1'b1;
				sel_addr = abyte;
				r.kind = KIND_ACK;
				r.addr = sel_addr;
				r.data = ACK_DATA;
				batch.push_back(r);
			end
		end
		if (sel_valid && flags[FLAG_WRITE]) begin
			r.kind = KIND_ACK;
			r.addr = sel_addr;
			r.data = ACK_DATA;
			batch.push_back(r);
			if (!ptr_loaded) begin
				reg_ptr = dbyte;
				ptr_loaded = 1'b1;
			end else begin
				reg_image[reg_ptr] = dbyte;
				step_pointer();
			end
		end
		if (sel_valid && flags[FLAG_READ]) begin
			r.kind = KIND_READ;
			r.addr = sel_addr;
			r.data = reg_image[reg_ptr];
			step_pointer();
			batch.push_back(r);
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			expected_replies.push_back(batch[i]);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: reply %0d %s expected 0x%02h actual 0x%02h",
				$time, reply_count, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t w;
		if (!arst_n) begin
			dev_addr = DEV_ADDR_RST;
			foreach (reg_image[i])
				reg_image[i] = 8'h00;
			reg_image[MODE1_IDX] = MODE1_RST;
			reg_image[MODE2_IDX] = MODE2_RST;
			reg_image[PRESCALE_IDX] = PRESCALE_RST;
			reg_ptr = 8'h00;
			sel_addr = 8'h00;
			sel_valid = 1'b0;
			ptr_loaded = 1'b0;
			expected_replies.delete();
			mismatch_count = 0;
			message_count = 0;
			reply_count = 0;
		end else begin
			// replies belong to earlier requests, so check them first
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t ns: reply kind %0d addr 0x%02h data 0x%02h last %0d with none pending",
						$time, m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tlast);
					mismatch_count++;
				end else begin
					w = expected_replies.pop_front();
					compare_field("kind", 8'(w.kind), 8'(m_tuser[0]));
					compare_field("address", w.addr, m_tdata[7:0]);
					compare_field("data", w.data, m_tdata[15:8]);
					compare_field("last", 8'(w.last), 8'(m_tlast));
				end
				reply_count++;
			end
			if (s_tvalid && s_tready) begin
				predict_replies(s_tuser, s_tdata[7:0], s_tdata[15:8]);
				message_count++;
			end
			if (cfg_we)
				dev_addr = cfg_data;
		end
		pending_replies = expected_replies.size();
	end

endmodule

[sim/tb_top.sv]
// Testbench top for the I2C register file slave: clock, reset, request stimulus,
// reply-side stalls, watchdog and verdict. Depends on i2crf_pkg, the slave top
// level and i2crf_reply_checker.
module tb_top
	import i2crf_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 12;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;
	logic [3:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;
	logic [0:0]        m_tuser;
	logic              m_tlast;

	int mismatch_count;
	int pending_replies;
	int message_count;
	int reply_count;
	int quiet_cycles;
	int settings_count;
	logic idle_on;
	logic [ADDR_W-1:0] dev_addr_now;

	i2c_register_file_slave_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	i2crf_reply_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatch_count  (mismatch_count),
		.pending_replies (pending_replies),
		.message_count   (message_count),
		.reply_count     (reply_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without progress, %0d replies pending",
				quiet_cycles, pending_replies);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// reply side: random stall bursts while idling is on
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && arst_n && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				m_tready = arst_n;
			end
		end
	end

	function automatic logic [7:0] addr_byte(input logic dir);
		return {dev_addr_now, dir};
	endfunction

	// one bus message per request, with an optional idle burst before it
	task automatic send_message(input logic stop, input logic start, input logic wr,
			input logic rd, input logic [7:0] abyte, input logic [7:0] dbyte);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {dbyte, abyte};
		s_tuser = {rd, wr, start, stop};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off until every reply is in, then let the slave settle
	task automatic wait_for_replies();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_replies != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_device_address(input logic [ADDR_W-1:0] value);
		wait_for_replies();
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		dev_addr_now = value;
		settings_count++;
	endtask

	// mostly well-formed transactions with random content, some noise
	task automatic random_traffic(input int target);
		int sent;
		int body;
		int op;
		int pick;
		logic [7:0] ptr;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// noise: any flag mix, address hit or miss
				send_message(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? addr_byte(1'($urandom_range(0, 1)))
						: 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				sent += 1;
			end else if (pick == 1) begin
				// rewrite MODE1, flipping auto-increment at random
				send_message(1'b1, 1'b1, 1'b1, 1'b0, addr_byte(1'($urandom_range(0, 1))),
					MODE1_IDX);
				send_message(1'b0, 1'b0, 1'b1, 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				send_message(1'b1, 1'b0, 1'b0, 1'b0, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				sent += 3;
			end else begin
				case ($urandom_range(0, 3))
					0: ptr = 8'($urandom_range(0, 255));
					1: ptr = 8'($urandom_range(0, 7));
					2: ptr = 8'($urandom_range(8'hFC, 8'hFF));
					default: ptr = PRESCALE_IDX;
				endcase
				send_message($urandom_range(0, 3) != 0, 1'b1, $urandom_range(0, 3) != 0,
					$urandom_range(0, 3) == 0, addr_byte(1'($urandom_range(0, 1))), ptr);
				body = $urandom_range(1, 6);
				repeat (body) begin
					op = $urandom_range(0, 2);
					send_message(1'b0, 1'b0, op != 1, op != 0, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
				sent += body + 1;
				// usually close with a stop; junk write or read after it is ignored
				if ($urandom_range(0, 3) != 0) begin
					send_message(1'b1, 1'b0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					sent += 1;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		idle_on = 1'b1;
		settings_count = 1;
		dev_addr_now = DEV_ADDR_RST;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset address: nothing selected yet, then a miss and a hit
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hFF);
		send_message(1'b0, 1'b1, 1'b1, 1'b1, {dev_addr_now + 7'd1, 1'b0}, 8'h00);
		send_message(1'b0, 1'b1, 1'b0, 1'b0, addr_byte(1'b0), 8'h00);
		// read before any pointer load gives MODE1 default
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, MODE2_IDX);
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
		// all three replies in one message, then turn auto-increment on
		send_message(1'b1, 1'b1, 1'b1, 1'b1, addr_byte(1'b1), MODE1_IDX);
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h31);
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
		// pointer wrap from the top of the map
		send_message(1'b1, 1'b1, 1'b1, 1'b1, addr_byte(1'b0), PRESCALE_IDX);
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hFF);
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
		// repeated start keeps the loaded pointer
		send_message(1'b0, 1'b1, 1'b0, 1'b1, addr_byte(1'b1), 8'h00);
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h55);
		// stop drops the selection before write and read
		send_message(1'b1, 1'b0, 1'b1, 1'b1, addr_byte(1'b0), 8'hAA);
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hAA);
		send_message(1'b1, 1'b1, 1'b1, 1'b1, addr_byte(1'b0), 8'h02);
		// missed start deselects a selected device
		send_message(1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 8'h77);
		send_message(1'b1, 1'b1, 1'b1, 1'b1, addr_byte(1'b0), 8'hFF);
		// auto-increment off again: the pointer holds
		send_message(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, MODE1_RST);
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);
		send_message(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00);

		// lowest address: address byte zero still selects
		set_device_address(7'd0);
		send_message(1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00);
		send_message(1'b0, 1'b1, 1'b1, 1'b1, 8'h01, 8'hAA);
		send_message(1'b0, 1'b1, 1'b0, 1'b1, 8'h02, 8'h00);

		// highest address, then random traffic over several settings
		set_device_address(7'd127);
		send_message(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 8'h10);
		send_message(1'b0, 1'b1, 1'b0, 1'b1, 8'hFC, 8'h00);
		random_traffic(22);
		repeat (3) begin
			set_device_address(7'($urandom_range(0, 127)));
			random_traffic(22);
		end
		set_device_address(DEV_ADDR_RST);
		idle_on = 1'b0;
		random_traffic(22);

		wait_for_replies();
		$display("run: %0d messages accepted, %0d replies checked, %0d address settings",
			message_count, reply_count, settings_count);
		$display("run: flag mixes, address hit and miss, pointer load, wrap and auto-increment");
		if (mismatch_count == 0 && pending_replies == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
